FILE: hdl/cubic_bezier_unit_tangent_unit_macros.svh
// ----------------------------------------------------------------------------
// cubic bezier unit tangent assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_UNIT_TANGENT_UNIT_MACROS_SVH
`define CUBIC_BEZIER_UNIT_TANGENT_UNIT_MACROS_SVH

// same-cycle implication
`define CBUT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbut check failed");

// next-cycle implication
`define CBUT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbut check failed");

`endif

FILE: hdl/cbut_pkg.sv
// ----------------------------------------------------------------------------
// cbut_pkg
// widths, constants and register map of the cubic bezier unit tangent unit
// ----------------------------------------------------------------------------
package cbut_pkg;

  localparam int NREG = 8;
  localparam int AW = 5;
  localparam logic [16:0] T_ONE = 17'd65536;
  localparam logic [15:0] Q_MAX = 16'h7fff;

  // pipeline depth: front end, root steps, numerator, divide steps, output
  localparam int NFRONT = 9;
  localparam int NROOT = 31;
  localparam int NDIV = 17;
  localparam int NSTG = NFRONT + NROOT + 1 + NDIV + 1;

  typedef enum logic [2:0] {
    REG_P0_X = 3'd0,
    REG_P0_Y = 3'd1,
    REG_P1_X = 3'd2,
    REG_P1_Y = 3'd3,
    REG_P2_X = 3'd4,
    REG_P2_Y = 3'd5,
    REG_P3_X = 3'd6,
    REG_P3_Y = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] ax;
    logic [30:0] ay;
    logic        nx;
    logic        ny;
    logic        zero;
  } side_t;

endpackage

FILE: hdl/cubic_bezier_unit_tangent_unit.sv
// ----------------------------------------------------------------------------
// cubic bezier unit tangent unit
// derivative of a cubic bezier at t, normalized to a signed Q1.15 unit vector
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// cfg      in         psel/penable/pwrite    paddr, pwdata, prdata
// in       in         in_valid/in_ready      param_t
// out      out        out_valid/out_ready    dir_x, dir_y, degenerate
//
// one transfer per cycle unless the output stalls, through a fixed pipeline:
// 9 front stages (weights, products, sums, shift search, normalize, squares),
// 31 square root steps, 1 numerator stage and 17 divide steps, 1 output stage.
// rst clears the control points and all stage valid bits.
// a stalled output freezes all stages; in_ready is out_ready or !out_valid.
// ----------------------------------------------------------------------------
`include "cubic_bezier_unit_tangent_unit_macros.svh"

module cubic_bezier_unit_tangent_unit
  import cbut_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AW-1:0]      paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [16:0]        param_t,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] dir_x,
  output logic signed [15:0] dir_y,
  output logic               degenerate
);

  logic [31:0] cfg [NREG];
  logic [NSTG-1:0] vld;
  logic en;

  assign pready = 1'b1;
  assign prdata = cfg[paddr[4:2]];
  assign en = out_ready || !vld[NSTG-1];
  assign in_ready = en;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREG; i++) cfg[i] <= '0;
    end else if (psel && penable && pwrite) begin
      cfg[paddr[4:2]] <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // stage 1: weights and control point differences
  logic [16:0] tc, uc;
  logic [31:0] ut;
  logic [32:0] s1_w [3];
  logic signed [32:0] s1_d [2][3];

  always_comb begin
    tc = (param_t > T_ONE) ? T_ONE : param_t;
    uc = 17'(T_ONE - tc);
    ut = 32'(uc * tc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_w[0] <= 33'(uc * uc);
      s1_w[1] <= {ut, 1'b0};
      s1_w[2] <= 33'(tc * tc);
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s1_d[a][i] <= $signed({cfg[2*(i+1)+a][31], cfg[2*(i+1)+a]})
                      - $signed({cfg[2*i+a][31], cfg[2*i+a]});
        end
      end
    end
  end

  // stage 2: products
  logic signed [65:0] s2_p [2][3];
  logic signed [65:0] mul_c [2][3];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < 3; i++) begin
        mul_c[a][i] = $signed({1'b0, s1_w[i][31:0]}) * s1_d[a][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < 3; i++) begin
          s2_p[a][i] <= s1_w[i][32] ? {s1_d[a][i][32], s1_d[a][i], 32'b0} : mul_c[a][i];
        end
      end
    end
  end

  // stage 3: weighted sums
  logic signed [67:0] s3_s [2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 2; a++) begin
        s3_s[a] <= 68'(s2_p[a][0]) + 68'(s2_p[a][1]) + 68'(s2_p[a][2]);
      end
    end
  end

  // stage 4: sign-change map, per byte leading position
  logic [71:0] gp;
  logic        nz_c [9];
  logic [2:0]  idx_c [9];
  logic        s4_nz [9];
  logic [2:0]  s4_idx [9];
  logic signed [67:0] s4_s [2];
  logic        s4_zero;

  always_comb begin
    gp = {5'b0, (s3_s[0][66:0] ^ s3_s[0][67:1]) | (s3_s[1][66:0] ^ s3_s[1][67:1])};
    for (int k = 0; k < 9; k++) begin
      nz_c[k] = |gp[8*k +: 8];
      idx_c[k] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (gp[8*k+b]) idx_c[k] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_nz <= nz_c;
      s4_idx <= idx_c;
      s4_s <= s3_s;
      s4_zero <= (s3_s[0] == '0) && (s3_s[1] == '0);
    end
  end

  // stage 5: shift amount
  logic [6:0] sh_c;
  logic [6:0] s5_sh;
  logic signed [67:0] s5_s [2];
  logic s5_zero;

  always_comb begin
    sh_c = 7'd0;
    for (int k = 0; k < 9; k++) begin
      if (s4_nz[k]) sh_c = 7'({4'(k), s4_idx[k]} + 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sh <= sh_c;
      s5_s <= s4_s;
      s5_zero <= s4_zero;
    end
  end

  // stage 6: coarse shift
  logic signed [97:0] cv [2];
  logic [37:0] s6_c [2];
  logic [2:0]  s6_sh;
  logic        s6_zero;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      cv[a] = $signed({s5_s[a], 30'b0}) >>> {s5_sh[6:3], 3'b000};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_c[0] <= cv[0][37:0];
      s6_c[1] <= cv[1][37:0];
      s6_sh <= s5_sh[2:0];
      s6_zero <= s5_zero;
    end
  end

  // stage 7: fine shift, magnitudes
  logic signed [37:0] fv [2];
  logic [30:0] nv [2];
  side_t s7_sd;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fv[a] = $signed(s6_c[a]) >>> s6_sh;
      nv[a] = fv[a][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_sd.ax <= nv[0][30] ? 31'(-nv[0]) : nv[0];
      s7_sd.ay <= nv[1][30] ? 31'(-nv[1]) : nv[1];
      s7_sd.nx <= nv[0][30];
      s7_sd.ny <= nv[1][30];
      s7_sd.zero <= s6_zero;
    end
  end

  // stage 8: squares
  logic [61:0] s8_qx, s8_qy;
  side_t s8_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_qx <= 62'(s7_sd.ax * s7_sd.ax);
      s8_qy <= 62'(s7_sd.ay * s7_sd.ay);
      s8_sd <= s7_sd;
    end
  end

  // stage 9 feeds the root steps
  logic [61:0] sq_n    [NROOT+1];
  logic [31:0] sq_rem  [NROOT+1];
  logic [30:0] sq_root [NROOT+1];
  side_t       sq_sd   [NROOT+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0] <= s8_qx + s8_qy;
      sq_rem[0] <= '0;
      sq_root[0] <= '0;
      sq_sd[0] <= s8_sd;
    end
  end

  for (genvar k = 0; k < NROOT; k++) begin : g_root
    logic [33:0] work, trial;
    logic        take;

    always_comb begin
      work = {sq_rem[k], sq_n[k][61-2*k -: 2]};
      trial = {1'b0, sq_root[k], 2'b01};
      take = (work >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[k+1] <= sq_n[k];
        sq_rem[k+1] <= take ? 32'(work - trial) : work[31:0];
        sq_root[k+1] <= {sq_root[k][29:0], take};
        sq_sd[k+1] <= sq_sd[k];
      end
    end
  end

  // numerator stage feeds the divide steps
  logic [46:0] dv_nx [NDIV+1];
  logic [46:0] dv_ny [NDIV+1];
  logic [30:0] dv_rx [NDIV+1];
  logic [30:0] dv_ry [NDIV+1];
  logic [16:0] dv_qx [NDIV+1];
  logic [16:0] dv_qy [NDIV+1];
  logic [30:0] dv_r  [NDIV+1];
  side_t       dv_sd [NDIV+1];
  logic [46:0] numx, numy;

  always_comb begin
    numx = {1'b0, sq_sd[NROOT].ax, 15'b0} + 47'(sq_root[NROOT][30:1]);
    numy = {1'b0, sq_sd[NROOT].ay, 15'b0} + 47'(sq_root[NROOT][30:1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_nx[0] <= numx;
      dv_ny[0] <= numy;
      dv_rx[0] <= {1'b0, numx[46:17]};
      dv_ry[0] <= {1'b0, numy[46:17]};
      dv_qx[0] <= '0;
      dv_qy[0] <= '0;
      dv_r[0] <= sq_root[NROOT];
      dv_sd[0] <= sq_sd[NROOT];
    end
  end

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    logic [31:0] wx, wy;
    logic        gx, gy;

    always_comb begin
      wx = {dv_rx[i], dv_nx[i][NDIV-1-i]};
      wy = {dv_ry[i], dv_ny[i][NDIV-1-i]};
      gx = (wx >= {1'b0, dv_r[i]});
      gy = (wy >= {1'b0, dv_r[i]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_nx[i+1] <= dv_nx[i];
        dv_ny[i+1] <= dv_ny[i];
        dv_rx[i+1] <= gx ? 31'(wx - {1'b0, dv_r[i]}) : wx[30:0];
        dv_ry[i+1] <= gy ? 31'(wy - {1'b0, dv_r[i]}) : wy[30:0];
        dv_qx[i+1] <= {dv_qx[i][15:0], gx};
        dv_qy[i+1] <= {dv_qy[i][15:0], gy};
        dv_r[i+1] <= dv_r[i];
        dv_sd[i+1] <= dv_sd[i];
      end
    end
  end

  // output stage: sign and saturation
  logic [16:0] qx, qy, mqx, mqy;

  always_comb begin
    qx = dv_qx[NDIV];
    qy = dv_qy[NDIV];
    mqx = 17'(~qx + 17'd1);
    mqy = 17'(~qy + 17'd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= dv_sd[NDIV].zero;
      priority if (dv_sd[NDIV].zero) begin
        dir_x <= '0;
        dir_y <= '0;
      end else begin
        dir_x <= dv_sd[NDIV].nx ? $signed(mqx[15:0])
               : ((qx > 17'(Q_MAX)) ? $signed(Q_MAX) : $signed(qx[15:0]));
        dir_y <= dv_sd[NDIV].ny ? $signed(mqy[15:0])
               : ((qy > 17'(Q_MAX)) ? $signed(Q_MAX) : $signed(qy[15:0]));
      end
    end
  end

  `CBUT_ASSERT_IMP(a_degen_zero, out_valid && degenerate, (dir_x == '0) && (dir_y == '0))
  `CBUT_ASSERT_IMP(a_unit_nonzero, out_valid && !degenerate, !((dir_x == '0) && (dir_y == '0)))
  `CBUT_ASSERT_IMP(a_root_norm, vld[NFRONT+NROOT] && !dv_sd[0].zero, dv_r[0][30:29] != 2'b00)

endmodule
